// File: src/pmst_pkg.sv
`default_nettype none

package pmst_pkg;

    localparam int SLOTS_DEFAULT = 64;
    localparam int PEER_W        = 16;
    localparam int SCORE_W       = 16;
    localparam int WEIGHT_W      = 16;
    localparam int CMD_W         = 2;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_W       = 1 + PEER_W + SCORE_W;

    localparam logic [SCORE_W-1:0] THRESH_RESET = 16'd100;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 2'd0,
        CMD_RESET = 2'd1,
        CMD_DECAY = 2'd2,
        CMD_QUERY = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_IGNORED = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_SCAN,
        BK_RESP
    } back_state_t;

    // One classified command as it waits in the queue.
    typedef struct packed {
        cmd_t                cmd;
        logic [PEER_W-1:0]   peer;
        logic [WEIGHT_W-2:0] w_mag;
        logic                ignored;
    } op_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } queue_head_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } back_ctrl_t;

endpackage

`default_nettype wire

// File: src/pmst_in_if.sv
`default_nettype none

interface pmst_in_if;
    logic                                valid;
    logic                                ready;
    logic [pmst_pkg::CMD_W-1:0]          command;
    logic [pmst_pkg::PEER_W-1:0]         peer_id;
    logic signed [pmst_pkg::WEIGHT_W-1:0] weight;

    modport source (output valid, command, peer_id, weight, input ready);
    modport sink   (input valid, command, peer_id, weight, output ready);
endinterface

`default_nettype wire

// File: src/pmst_out_if.sv
`default_nettype none

interface pmst_out_if;
    logic                          valid;
    logic                          ready;
    logic [pmst_pkg::SCORE_W-1:0]  score;
    logic                          crossed;
    logic [pmst_pkg::STATUS_W-1:0] status;

    modport source (output valid, score, crossed, status, input ready);
    modport sink   (input valid, score, crossed, status, output ready);
endinterface

`default_nettype wire

// File: src/peer_misbehavior_score_table_unit.sv
`default_nettype none

// Per-peer misbehaviour score table with a ban threshold.
// Commands arrive on req (valid/ready): add a weight, reset a peer, decay all
// scores by one, or query a score. Each command gives exactly one beat on rsp
// (valid/ready) with the score, the crossed flag and a status code.
// The user writes the ban threshold through cfg_write_en/cfg_write_data only
// while the block is idle (not enforced by the block); it resets to 100.
// A two-entry queue sits behind req, so commands are taken while the table
// engine is busy. The engine scans the slot memory one slot per cycle through
// its single read port: add, reset and query stop the scan at the slot that
// holds the peer and otherwise scan every slot; decay always scans every slot
// and an ignored add skips the scan. After each result the engine goes back to
// idle and then takes the next queued command. After reset the engine clears
// every slot, one per cycle; req.ready stays low during that pass.
// The result sits in an output register; while rsp is stalled the engine
// scans at most one more command and waits with it, and the queue then fills and
// drops req.ready.

module peer_misbehavior_score_table_unit #(
    parameter int SLOTS = pmst_pkg::SLOTS_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    pmst_in_if.sink                            req,
    pmst_out_if.source                         rsp,
    input  wire logic                          cfg_write_en,
    input  wire logic [pmst_pkg::SCORE_W-1:0]  cfg_write_data
);
    logic [pmst_pkg::SCORE_W-1:0] thresh_reg, thresh_next;
    pmst_pkg::queue_head_t        head;
    pmst_pkg::back_ctrl_t         ctrl;

    assign thresh_next = cfg_write_en ? cfg_write_data : thresh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= pmst_pkg::THRESH_RESET;
        end
        else
        begin
            thresh_reg <= thresh_next;
        end
    end

    pmst_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .ctrl  (ctrl),
        .head  (head)
    );

    pmst_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .ctrl      (ctrl),
        .threshold (thresh_reg),
        .rsp       (rsp)
    );
endmodule

`default_nettype wire

// File: src/pmst_ram.sv
`default_nettype none

module pmst_ram #(
    parameter int WIDTH = pmst_pkg::ENTRY_W,
    parameter int DEPTH = pmst_pkg::SLOTS_DEFAULT
) (
    input  wire logic                                          clk,
    input  wire logic                                          wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
    input  wire logic [WIDTH-1:0]                              wr_data,
    input  wire logic                                          rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
    output logic      [WIDTH-1:0]                              rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

`default_nettype wire

// File: src/pmst_front.sv
`default_nettype none

module pmst_front (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    pmst_in_if.sink                     req,
    input  wire pmst_pkg::back_ctrl_t   ctrl,
    output pmst_pkg::queue_head_t       head
);
    pmst_pkg::op_t ent_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic          push;
    logic          pop;
    pmst_pkg::op_t op_in;

    // No beat is taken while the table is being cleared after reset.
    assign req.ready = (cnt_reg != 2'd2) && !ctrl.clearing;
    assign push      = req.valid && req.ready;
    assign pop       = ctrl.pop && (cnt_reg != 2'd0);

    always_comb
    begin
        op_in.cmd     = pmst_pkg::cmd_t'(req.command);
        op_in.peer    = req.peer_id;
        op_in.w_mag   = req.weight[pmst_pkg::WEIGHT_W-2:0];
        op_in.ignored = (pmst_pkg::cmd_t'(req.command) == pmst_pkg::CMD_ADD) &&
                        (req.weight[pmst_pkg::WEIGHT_W-1] ||
                         (req.weight == '0));
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= op_in;
        end
    end

    assign head.valid = (cnt_reg != 2'd0);
    assign head.op    = ent_reg[rd_ptr_reg];
endmodule

`default_nettype wire

// File: src/pmst_back.sv
`default_nettype none

module pmst_back #(
    parameter int SLOTS = pmst_pkg::SLOTS_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire pmst_pkg::queue_head_t         head,
    output pmst_pkg::back_ctrl_t               ctrl,
    input  wire logic [pmst_pkg::SCORE_W-1:0]  threshold,
    pmst_out_if.source                         rsp
);
    localparam int ADDR_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int ENTRY_W = pmst_pkg::ENTRY_W;
    localparam int SCORE_W = pmst_pkg::SCORE_W;
    localparam int PEER_W  = pmst_pkg::PEER_W;

    pmst_pkg::back_state_t state_reg, state_next;
    pmst_pkg::op_t         op_reg, op_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  chk_pend_reg, chk_pend_next;
    logic [ADDR_W-1:0]     chk_addr_reg, chk_addr_next;
    logic                  hit_reg, hit_next;
    logic [ADDR_W-1:0]     idx_reg, idx_next;
    logic [SCORE_W-1:0]    cur_score_reg, cur_score_next;
    logic                  free_found_reg, free_found_next;
    logic [ADDR_W-1:0]     free_idx_reg, free_idx_next;

    logic                  out_valid_reg, out_valid_next;
    logic [SCORE_W-1:0]    out_score_reg, out_score_next;
    logic                  out_crossed_reg, out_crossed_next;
    pmst_pkg::status_t     out_status_reg, out_status_next;

    logic                  ram_wr_en;
    logic [ADDR_W-1:0]     ram_wr_addr;
    logic [ENTRY_W-1:0]    ram_wr_data;
    logic                  ram_rd_en;
    logic [ADDR_W-1:0]     ram_rd_addr;
    logic [ENTRY_W-1:0]    ram_rd_data;

    logic                  rd_valid;
    logic [PEER_W-1:0]     rd_peer;
    logic [SCORE_W-1:0]    rd_score;
    logic                  issue;
    logic                  out_free;
    logic                  out_load;
    logic [SCORE_W:0]      sum;
    logic [SCORE_W-1:0]    sat;
    logic [SCORE_W-1:0]    res_score;
    logic                  res_crossed;
    pmst_pkg::status_t     res_status;

    // Each entry holds its valid mark, the peer and the score in one word.
    pmst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign rd_valid = ram_rd_data[ENTRY_W-1];
    assign rd_peer  = ram_rd_data[ENTRY_W-2 -: PEER_W];
    assign rd_score = ram_rd_data[SCORE_W-1:0];

    assign out_free = !out_valid_reg || rsp.ready;
    assign issue    = (cnt_reg < CNT_W'(SLOTS));

    // The new score saturates; a fresh entry starts from zero.
    assign sum = {1'b0, (hit_reg ? cur_score_reg : {SCORE_W{1'b0}})} +
                 {2'b00, op_reg.w_mag};
    assign sat = sum[SCORE_W] ? {SCORE_W{1'b1}} : sum[SCORE_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        cnt_next        = cnt_reg;
        chk_pend_next   = chk_pend_reg;
        chk_addr_next   = chk_addr_reg;
        hit_next        = hit_reg;
        idx_next        = idx_reg;
        cur_score_next  = cur_score_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = chk_addr_reg;
        ram_wr_data = '0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = cnt_reg[ADDR_W-1:0];

        ctrl.pop      = 1'b0;
        ctrl.clearing = (state_reg == pmst_pkg::BK_CLEAR);

        out_load    = 1'b0;
        res_score   = '0;
        res_crossed = 1'b0;
        res_status  = pmst_pkg::ST_DONE;

        case (state_reg)
            pmst_pkg::BK_CLEAR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = cnt_reg[ADDR_W-1:0];
                if (cnt_reg == CNT_W'(SLOTS - 1))
                begin
                    cnt_next   = '0;
                    state_next = pmst_pkg::BK_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            pmst_pkg::BK_IDLE:
            begin
                if (head.valid)
                begin
                    ctrl.pop        = 1'b1;
                    op_next         = head.op;
                    cnt_next        = '0;
                    chk_pend_next   = 1'b0;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = head.op.ignored ? pmst_pkg::BK_RESP
                                                      : pmst_pkg::BK_SCAN;
                end
            end

            pmst_pkg::BK_SCAN:
            begin
                // Reads are issued one slot ahead of the slot being checked.
                ram_rd_en     = issue;
                chk_pend_next = issue;
                chk_addr_next = cnt_reg[ADDR_W-1:0];
                if (issue)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (chk_pend_reg)
                begin
                    if (op_reg.cmd == pmst_pkg::CMD_DECAY)
                    begin
                        if (rd_valid && (rd_score != '0))
                        begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = chk_addr_reg;
                            ram_wr_data = {1'b1, rd_peer, rd_score - 1'b1};
                        end
                    end
                    else
                    begin
                        if (rd_valid && (rd_peer == op_reg.peer))
                        begin
                            hit_next       = 1'b1;
                            idx_next       = chk_addr_reg;
                            cur_score_next = rd_score;
                            state_next     = pmst_pkg::BK_RESP;
                        end
                        if (!rd_valid && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = chk_addr_reg;
                        end
                    end
                end
                if (!issue && !chk_pend_reg)
                begin
                    state_next = pmst_pkg::BK_RESP;
                end
            end

            pmst_pkg::BK_RESP:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = pmst_pkg::BK_IDLE;
                    case (op_reg.cmd)
                        pmst_pkg::CMD_ADD:
                        begin
                            if (op_reg.ignored)
                            begin
                                res_status = pmst_pkg::ST_IGNORED;
                            end
                            else if (hit_reg || free_found_reg)
                            begin
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = hit_reg ? idx_reg : free_idx_reg;
                                ram_wr_data = {1'b1, op_reg.peer, sat};
                                res_score   = sat;
                                res_crossed = (sat >= threshold);
                            end
                            else
                            begin
                                res_status = pmst_pkg::ST_FULL;
                            end
                        end
                        pmst_pkg::CMD_RESET:
                        begin
                            if (hit_reg)
                            begin
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = idx_reg;
                            end
                        end
                        pmst_pkg::CMD_QUERY:
                        begin
                            res_score = hit_reg ? cur_score_reg : '0;
                        end
                        default:
                        begin
                            res_score = '0;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = pmst_pkg::BK_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
        out_score_next   = out_load ? res_score : out_score_reg;
        out_crossed_next = out_load ? res_crossed : out_crossed_reg;
        out_status_next  = out_load ? res_status : out_status_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pmst_pkg::BK_CLEAR;
            cnt_reg        <= '0;
            chk_pend_reg   <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            chk_pend_reg   <= chk_pend_next;
            hit_reg        <= hit_next;
            free_found_reg <= free_found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        chk_addr_reg    <= chk_addr_next;
        idx_reg         <= idx_next;
        cur_score_reg   <= cur_score_next;
        free_idx_reg    <= free_idx_next;
        out_score_reg   <= out_score_next;
        out_crossed_reg <= out_crossed_next;
        out_status_reg  <= out_status_next;
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.score   = out_score_reg;
    assign rsp.crossed = out_crossed_reg;
    assign rsp.status  = out_status_reg;
endmodule

`default_nettype wire

// File: src/pmst_checker.sv
`default_nettype none

module pmst_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           rsp_valid,
    input wire logic                           rsp_ready,
    input wire logic [pmst_pkg::SCORE_W-1:0]   rsp_score,
    input wire logic                           rsp_crossed,
    input wire logic [pmst_pkg::STATUS_W-1:0]  rsp_status
);
    // A result beat held back by the receiver keeps its contents.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_score) &&
            $stable(rsp_crossed) && $stable(rsp_status))
        else $error("result beat changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_status == pmst_pkg::ST_DONE) ||
            (rsp_status == pmst_pkg::ST_IGNORED) ||
            (rsp_status == pmst_pkg::ST_FULL))
        else $error("unknown status code");

    // Crossing only follows an effective add, which always leaves a score.
    a_crossed_add: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_crossed |->
            (rsp_status == pmst_pkg::ST_DONE) && (rsp_score != '0))
        else $error("crossed flag without an effective add");

    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != pmst_pkg::ST_DONE) |->
            (rsp_score == '0) && !rsp_crossed)
        else $error("rejected add carries a score");
endmodule

bind peer_misbehavior_score_table_unit pmst_checker u_pmst_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_score   (rsp.score),
    .rsp_crossed (rsp.crossed),
    .rsp_status  (rsp.status)
);

`default_nettype wire
